// ----- hw/rtl/mf5d_pkg.sv -----
// Shared widths, register indexes and reset values of the depth median filter.
package mf5d_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned MAX_ROWS  = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [COORD_W-1:0]  coord_t;

endpackage

// ----- hw/rtl/median_filter_5x5_depth_top.sv -----
// Streaming median filter over a square window of depth samples, top level.
//
// Usage: depth samples enter in raster order on the input channel, one item
// per cycle, with frame_start_i marking the first pixel of each frame. For
// every pixel at least WIN_SIDE/2 pixels away from all edges the block sends
// one item carrying the window median, the pixel's row and column, and a
// frame_done flag on the last interior pixel. Border pixels send nothing.
// Frame size is set through the configuration channel (index 0 is the width,
// index 1 the height); it is always ready and should be written while idle.
// Throughput: one item per cycle while the receiver does not stall.
// The pipeline is: line memory read, window update and memory write-back,
// pairwise compare matrix, rank count, and the output register.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops as
// long as a finished result sits unclaimed in the output register.
// Reset clears the counters, window and valid bits and loads 640 x 480.
// The line memories are not cleared; stale contents never reach a result.
module median_filter_5x5_depth_top
  import mf5d_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned WIN_SIDE  = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Sample input channel.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SAMPLE_W-1:0]  depth_sample_i,
  input  logic                 frame_start_i,
  // Result output channel.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SAMPLE_W-1:0]  median_value_o,
  output logic [COORD_W-1:0]   out_row_o,
  output logic [COORD_W-1:0]   out_col_o,
  output logic                 frame_done_o,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned LINES = WIN_SIDE - 1;
  localparam int unsigned HALF  = WIN_SIDE / 2;
  localparam int unsigned AREA  = WIN_SIDE * WIN_SIDE;
  localparam int unsigned RANK  = AREA / 2;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned LW    = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int unsigned XW    = (CW > COORD_W) ? CW : COORD_W;
  localparam int unsigned NW    = $clog2(AREA);

  // Configuration registers.
  logic [CFG_W-1:0] frame_width_q, frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame size, saturated to the supported range.
  logic [LW-1:0]    width_ext, eff_w, w_last;
  logic [CFG_W-1:0] eff_h, h_last;

  always_comb begin
    width_ext = LW'(frame_width_q);
    if (width_ext < LW'(WIN_SIDE)) begin
      eff_w = LW'(WIN_SIDE);
    end else if (width_ext > LW'(MAX_WIDTH)) begin
      eff_w = LW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
    if (frame_height_q < CFG_W'(WIN_SIDE)) begin
      eff_h = CFG_W'(WIN_SIDE);
    end else if (frame_height_q > CFG_W'(MAX_ROWS)) begin
      eff_h = CFG_W'(MAX_ROWS);
    end else begin
      eff_h = frame_height_q;
    end
    w_last = eff_w - LW'(1);
    h_last = eff_h - CFG_W'(1);
  end

  // The whole pipeline advances together whenever the output register can
  // take a new value.
  logic en, in_acc;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign in_acc     = in_valid_i && en;

  // Raster position of the incoming sample.
  logic [CW-1:0]      col_q, col_cur, col_d;
  logic [COORD_W-1:0] row_q, row_cur, row_d;
  logic               emit_cur, done_cur;
  logic [XW-1:0]      col_ctr;
  logic [COORD_W-1:0] row_ctr;

  always_comb begin
    col_cur  = frame_start_i ? '0 : col_q;
    row_cur  = frame_start_i ? '0 : row_q;
    emit_cur = (row_cur >= COORD_W'(WIN_SIDE - 1)) && (col_cur >= CW'(WIN_SIDE - 1));
    done_cur = (CFG_W'(row_cur) == h_last) && (LW'(col_cur) == w_last);
    col_ctr  = XW'(col_cur) - XW'(HALF);
    row_ctr  = row_cur - COORD_W'(HALF);
    if (LW'(col_cur) >= w_last) begin
      col_d = '0;
      row_d = (CFG_W'(row_cur) >= h_last) ? '0 : row_cur + COORD_W'(1);
    end else begin
      col_d = col_cur + CW'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: line memory data arrives; the new column is assembled.
  logic               s1_valid_q, s1_emit_q, s1_done_q, fwd_q;
  sample_t            s1_sample_q;
  logic [CW-1:0]      s1_col_q;
  logic [COORD_W-1:0] s1_row_out_q, s1_col_out_q;
  sample_t            fwd_data_q [LINES];
  sample_t            line_rd [LINES];
  sample_t            col_vec [WIN_SIDE];
  logic               wr_en;

  assign wr_en = en && s1_valid_q;

  always_comb begin
    for (int r = 0; r < LINES; r++) begin
      col_vec[r] = fwd_q ? fwd_data_q[r] : line_rd[r];
    end
    col_vec[LINES] = s1_sample_q;
  end

  // One memory per stored line; entry at a column holds that column's sample
  // from the matching earlier row.
  for (genvar g = 0; g < LINES; g++) begin : g_line
    sample_t mem [MAX_WIDTH];
    sample_t rd_q;
    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem[s1_col_q] <= col_vec[g+1];
      end
      if (in_acc) begin
        rd_q <= mem[col_cur];
      end
    end
    assign line_rd[g] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_acc;
      // A write-back to the column being read in the same cycle is not seen
      // by the memory read, so that data is forwarded instead.
      fwd_q      <= in_acc && s1_valid_q && (col_cur == s1_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q  <= depth_sample_i;
      s1_col_q     <= col_cur;
      s1_emit_q    <= emit_cur;
      s1_done_q    <= done_cur;
      s1_row_out_q <= row_ctr;
      s1_col_out_q <= col_ctr[COORD_W-1:0];
      for (int r = 0; r < LINES; r++) begin
        fwd_data_q[r] <= col_vec[r+1];
      end
    end
  end

  // Window registers: shift left one column and insert the new column.
  sample_t win_q [AREA];
  sample_t win_d [AREA];

  always_comb begin
    for (int r = 0; r < WIN_SIDE; r++) begin
      for (int c = 0; c < WIN_SIDE - 1; c++) begin
        win_d[r*WIN_SIDE+c] = win_q[r*WIN_SIDE+c+1];
      end
      win_d[r*WIN_SIDE+WIN_SIDE-1] = col_vec[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AREA; i++) begin
        win_q[i] <= '0;
      end
    end else if (wr_en) begin
      win_q <= win_d;
    end
  end

  // Stage 2: the updated window is complete; carry the pixel's coordinates.
  logic               s2_valid_q, s2_done_q;
  logic [COORD_W-1:0] s2_row_q, s2_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_row_q  <= s1_row_out_q;
      s2_col_q  <= s1_col_out_q;
      s2_done_q <= s1_done_q;
    end
  end

  // Stage 3: compare matrix. Bit j of row i says element j sorts before
  // element i; equal values are ordered by position so ranks are unique.
  logic               s3_valid_q, s3_done_q;
  logic [COORD_W-1:0] s3_row_q, s3_col_q;
  logic [AREA-1:0]    lt_q [AREA];
  sample_t            v3_q [AREA];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
      s3_done_q <= s2_done_q;
      v3_q      <= win_q;
      for (int i = 0; i < AREA; i++) begin
        for (int j = 0; j < AREA; j++) begin
          lt_q[i][j] <= (j != i) &&
                        ((win_q[j] < win_q[i]) || ((j < i) && (win_q[j] == win_q[i])));
        end
      end
    end
  end

  // Stage 4: the element whose rank equals the middle rank is the median.
  logic               s4_valid_q, s4_done_q;
  logic [COORD_W-1:0] s4_row_q, s4_col_q;
  logic [AREA-1:0]    s4_sel_q;
  sample_t            v4_q [AREA];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_row_q  <= s3_row_q;
      s4_col_q  <= s3_col_q;
      s4_done_q <= s3_done_q;
      v4_q      <= v3_q;
      for (int i = 0; i < AREA; i++) begin
        s4_sel_q[i] <= (NW'($countones(lt_q[i])) == NW'(RANK));
      end
    end
  end

  // Output register: one-hot select of the median value.
  logic               out_valid_q, out_done_q;
  logic [COORD_W-1:0] out_row_q, out_col_q;
  sample_t            out_med_q, med_sel;

  always_comb begin
    med_sel = '0;
    for (int i = 0; i < AREA; i++) begin
      med_sel = med_sel | (v4_q[i] & {SAMPLE_W{s4_sel_q[i]}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s4_valid_q) begin
      out_med_q  <= med_sel;
      out_row_q  <= s4_row_q;
      out_col_q  <= s4_col_q;
      out_done_q <= s4_done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_value_o = out_med_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign frame_done_o   = out_done_q;

  // Exactly one window element must hold the middle rank.
  a_single_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |-> $onehot(s4_sel_q))
    else $error("median select is not one-hot");

  // Forwarding is only armed behind an item that is writing back.
  a_fwd_needs_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forward set without a pending write-back");

  // A frame start restarts the raster at column zero, so the next is one.
  a_frame_start_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_start_i) |=> (col_q == CW'(1)))
    else $error("column counter did not restart on frame start");

endmodule
